/* hw/rtl/sparse_set_membership_top_macros.svh */
// Assertion macros shared by the sparse set checker.
`ifndef SPARSE_SET_MEMBERSHIP_TOP_MACROS_SVH
`define SPARSE_SET_MEMBERSHIP_TOP_MACROS_SVH

// Clocked check, masked while reset is held.
`define SSM_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also runs through reset.
`define SSM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* hw/rtl/ssm_pkg.sv */
// Types and constants for the sparse set membership block.
`default_nettype none

package ssm_pkg;

    localparam int unsigned IdxW       = 7;
    localparam int unsigned TableDepth = 1 << IdxW;
    localparam int unsigned MaxValue   = 127;
    localparam logic [IdxW-1:0] CountFull = IdxW'(TableDepth - 1);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic clear;     // zero the count
        logic flag_bad;  // result carries the invalid flag
        logic rd_slot;   // sparse data is back, look up dense at that slot
        logic check;     // dense data is back, membership is known
        logic rd_last;   // fetch the last dense member
        logic do_insert; // append value
        logic do_swap;   // move last member into the hole
        logic emit;      // register a result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_clear;
        logic in_bad;
        logic is_insert;
        logic is_remove;
        logic present;
        logic not_full;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hw/rtl/sparse_set_membership_top.sv */
// Top level of the sparse set membership block.
// Usage:
//   Drive i_action / i_value with start high; the beat is taken at an edge
//   where start is high and busy is low. Each beat gives exactly one result,
//   shown on o_was_present / o_member_count / o_bad_value for one cycle
//   while o_valid is high. The receiver cannot stall; results are not held.
// Sequence, from the cycle in which the beat is taken:
//   clear or zero value: the result is registered, busy stays low, so one
//     beat per cycle is possible.
//   insert, find, remove of an absent value: busy through the lookup, slot
//     and check states; the result shows as busy drops, and the next beat
//     can be taken then. Remove of a member: busy also in the last state.
//   The states follow the chain of registered reads through the single
//   read port of each table: sparse index, then dense slot, then last member.
// Reset (synchronous, active low) empties the set at once: count goes to
// zero, unwritten sparse entries read as zero, dense ones never match.
`default_nettype none

module sparse_set_membership_top (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_action,
    input  wire logic [ssm_pkg::IdxW-1:0] i_value,
    output logic                          o_valid,
    output logic                          o_was_present,
    output logic      [ssm_pkg::IdxW-1:0] o_member_count,
    output logic                          o_bad_value
);

    import ssm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ssm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ssm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_was_present  (o_was_present),
        .o_member_count (o_member_count),
        .o_bad_value    (o_bad_value)
    );

endmodule

`default_nettype wire

/* hw/rtl/ssm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssm_ram #(
    parameter int Width = 7,
    parameter int Depth = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/ssm_ctrl.sv */
// Sequencer for the sparse set: lookup, check and update steps.
`default_nettype none

module ssm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire ssm_pkg::t_dp_stat i_stat,
    output ssm_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);

    import ssm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOOK = 5'b00010,
        ST_SLOT = 5'b00100,
        ST_CHK  = 5'b01000,
        ST_LAST = 5'b10000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    if (i_stat.in_clear) begin
                        cmd.clear = 1'b1;
                        cmd.emit  = 1'b1;
                    end else if (i_stat.in_bad) begin
                        cmd.flag_bad = 1'b1;
                        cmd.emit     = 1'b1;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                // sparse read address is the captured value
                n_state = ST_SLOT;
            end
            ST_SLOT: begin
                cmd.rd_slot = 1'b1;
                n_state     = ST_CHK;
            end
            ST_CHK: begin
                cmd.check = 1'b1;
                if (i_stat.is_insert && !i_stat.present && i_stat.not_full) begin
                    cmd.do_insert = 1'b1;
                end
                if (i_stat.is_remove && i_stat.present) begin
                    cmd.rd_last = 1'b1;
                    n_state     = ST_LAST;
                end else begin
                    cmd.emit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_LAST: begin
                cmd.do_swap = 1'b1;
                cmd.emit    = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/ssm_datapath.sv */
// Sparse index table, dense member list, count and result registers.
`default_nettype none

module ssm_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [1:0]               i_action,
    input  wire logic [ssm_pkg::IdxW-1:0] i_value,
    input  wire ssm_pkg::t_dp_cmd         i_cmd,
    output ssm_pkg::t_dp_stat             o_stat,
    output logic                          o_valid,
    output logic                          o_was_present,
    output logic      [ssm_pkg::IdxW-1:0] o_member_count,
    output logic                          o_bad_value
);

    import ssm_pkg::*;

    t_action           r_action;
    logic [IdxW-1:0]   r_value;
    logic [IdxW-1:0]   r_count;
    logic [IdxW-1:0]   n_count;
    logic [IdxW-1:0]   r_slot;
    logic              r_present;

    // written flags: unwritten sparse reads 0, dense never matches
    logic [TableDepth-1:0] r_sp_vld;
    logic [TableDepth-1:0] r_dn_vld;
    logic                  r_sp_vld_q;
    logic                  r_dn_vld_q;

    logic              r_o_valid;
    logic              r_o_present;
    logic [IdxW-1:0]   r_o_count;
    logic              r_o_bad;

    logic              mem_we;
    logic [IdxW-1:0]   sp_ra;
    logic [IdxW-1:0]   sp_wa;
    logic [IdxW-1:0]   sp_wd;
    logic [IdxW-1:0]   sp_rdata;
    logic [IdxW-1:0]   dn_ra;
    logic [IdxW-1:0]   dn_wa;
    logic [IdxW-1:0]   dn_wd;
    logic [IdxW-1:0]   dn_rdata;
    logic [IdxW-1:0]   slot_c;
    logic [IdxW-1:0]   last_val;
    logic              present_c;
    logic              in_bad;

    assign in_bad = (i_value == '0) || (32'(i_value) > MaxValue);

    assign slot_c    = r_sp_vld_q ? sp_rdata : '0;
    assign last_val  = dn_rdata;
    assign present_c = (r_slot < r_count) && r_dn_vld_q && (dn_rdata == r_value);

    assign mem_we = i_cmd.do_insert | i_cmd.do_swap;

    assign sp_ra = r_value;
    assign sp_wa = i_cmd.do_insert ? r_value : last_val;
    assign sp_wd = i_cmd.do_insert ? r_count : r_slot;

    assign dn_ra = i_cmd.rd_last ? (r_count - IdxW'(1)) : slot_c;
    assign dn_wa = i_cmd.do_insert ? r_count : r_slot;
    assign dn_wd = i_cmd.do_insert ? r_value : last_val;

    ssm_ram #(
        .Width (IdxW),
        .Depth (TableDepth)
    ) u_sparse (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (sp_wa),
        .i_wdata (sp_wd),
        .i_raddr (sp_ra),
        .o_rdata (sp_rdata)
    );

    ssm_ram #(
        .Width (IdxW),
        .Depth (TableDepth)
    ) u_dense (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (dn_wa),
        .i_wdata (dn_wd),
        .i_raddr (dn_ra),
        .o_rdata (dn_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.do_insert) begin
            n_count = r_count + IdxW'(1);
        end else if (i_cmd.do_swap) begin
            n_count = r_count - IdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sp_vld  <= '0;
            r_dn_vld  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_o_valid <= i_cmd.emit;
            if (mem_we) begin
                r_sp_vld[sp_wa] <= 1'b1;
                r_dn_vld[dn_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp_vld_q <= r_sp_vld[sp_ra];
        r_dn_vld_q <= r_dn_vld[dn_ra];
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_value  <= i_value;
        end
        if (i_cmd.rd_slot) begin
            r_slot <= slot_c;
        end
        if (i_cmd.check) begin
            r_present <= present_c;
        end
        if (i_cmd.emit) begin
            r_o_present <= (i_cmd.check && present_c) || (i_cmd.do_swap && r_present);
            r_o_count   <= n_count;
            r_o_bad     <= i_cmd.flag_bad;
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.in_clear  = (t_action'(i_action) == ACT_CLEAR);
        o_stat.in_bad    = in_bad;
        o_stat.is_insert = (r_action == ACT_INSERT);
        o_stat.is_remove = (r_action == ACT_REMOVE);
        o_stat.present   = present_c;
        o_stat.not_full  = (r_count != CountFull);
    end

    assign o_valid        = r_o_valid;
    assign o_was_present  = r_o_present;
    assign o_member_count = r_o_count;
    assign o_bad_value    = r_o_bad;

endmodule

`default_nettype wire

/* hw/rtl/ssm_checker.sv */
// Port-level checks for the sparse set block, bound to the top level.
`default_nettype none

`include "sparse_set_membership_top_macros.svh"

module ssm_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic [1:0]               i_action,
    input wire logic [ssm_pkg::IdxW-1:0] i_value,
    input wire logic                     o_valid,
    input wire logic                     o_was_present,
    input wire logic [ssm_pkg::IdxW-1:0] o_member_count,
    input wire logic                     o_bad_value
);

    import ssm_pkg::*;

    // clear answers on the next cycle with an empty set
    `SSM_ASSERT_CLK(a_clear_result,
        (start && !busy && i_action == ACT_CLEAR) |=>
        (o_valid && o_member_count == '0 && !o_was_present && !o_bad_value),
        "clear did not give an empty result")

    // a result beat always closes the item
    `SSM_ASSERT_CLK(a_result_idle, o_valid |-> !busy, "result shown while still busy")

    // zero key is rejected on the next cycle and never reported as a member
    `SSM_ASSERT_CLK(a_zero_rejected,
        (start && !busy && i_action != ACT_CLEAR && i_value == '0) |=>
        (o_valid && o_bad_value && !o_was_present),
        "zero key not flagged as invalid")

    `SSM_ASSERT_RST(a_reset_quiet, (!i_rst_n) |=> (!busy && !o_valid), "block not quiet after reset")

endmodule

bind sparse_set_membership_top ssm_checker u_ssm_checker (.*);

`default_nettype wire
